// ----- rtl/vlg3d_pkg.sv -----
// Shared types, constants and helpers for the 3D voxel line generator.
`timescale 1ns / 1ps
`default_nettype none
package vlg3d_pkg;

    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int CNT_W     = 6;
    localparam int DEC_W     = 9;

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic signed [DEC_W-1:0] dec_t;
    typedef logic signed [1:0]       dir_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_INIT,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic calc_diff;
        logic calc_init;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

    function automatic coord_t clamp_coord(input coord_t c);
        coord_t r;
        r = c;
        if (c > COORD_W'(GRID_SIZE - 1)) begin
            r = COORD_W'(GRID_SIZE - 1);
        end
        return r;
    endfunction

    function automatic axis_t minor1(input axis_t maj);
        axis_t r;
        r = (maj == AX_X) ? AX_Y : AX_X;
        return r;
    endfunction

    function automatic axis_t minor2(input axis_t maj);
        axis_t r;
        r = (maj == AX_Z) ? AX_Y : AX_Z;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/vlg3d_ctrl.sv -----
// Controller state machine: sequences load, setup and the voxel walk.
`timescale 1ns / 1ps
`default_nettype none
module vlg3d_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vlg3d_pkg::cmd_t        cmd,
    input  wire vlg3d_pkg::status_t status
);

    vlg3d_pkg::state_t state_reg;
    vlg3d_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vlg3d_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vlg3d_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = vlg3d_pkg::ST_DIFF;
                end
            end
            vlg3d_pkg::ST_DIFF: state_next = vlg3d_pkg::ST_INIT;
            vlg3d_pkg::ST_INIT: state_next = vlg3d_pkg::ST_WALK;
            vlg3d_pkg::ST_WALK: begin
                if (m_ready && status.last) begin
                    state_next = vlg3d_pkg::ST_IDLE;
                end
            end
            default: state_next = vlg3d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        case (state_reg)
            vlg3d_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            vlg3d_pkg::ST_DIFF: cmd.calc_diff = 1'b1;
            vlg3d_pkg::ST_INIT: cmd.calc_init = 1'b1;
            vlg3d_pkg::ST_WALK: begin
                m_valid  = 1'b1;
                cmd.step = m_ready && !status.last;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/vlg3d_dpath.sv -----
// Datapath: end points, extents, decision terms and the walker position.
`timescale 1ns / 1ps
`default_nettype none
module vlg3d_dpath (
    input  wire logic              aclk,
    input  wire vlg3d_pkg::cmd_t   cmd,
    input  wire vlg3d_pkg::coord_t start_x,
    input  wire vlg3d_pkg::coord_t start_y,
    input  wire vlg3d_pkg::coord_t start_z,
    input  wire vlg3d_pkg::coord_t end_x,
    input  wire vlg3d_pkg::coord_t end_y,
    input  wire vlg3d_pkg::coord_t end_z,
    output vlg3d_pkg::coord_t      voxel_x,
    output vlg3d_pkg::coord_t      voxel_y,
    output vlg3d_pkg::coord_t      voxel_z,
    output vlg3d_pkg::status_t     status
);

    vlg3d_pkg::coord_t p_reg [3];
    vlg3d_pkg::coord_t p_next[3];
    vlg3d_pkg::coord_t e_reg [3];
    vlg3d_pkg::coord_t d_reg [3];
    vlg3d_pkg::dir_t   s_reg [3];
    vlg3d_pkg::axis_t  maj_reg;
    vlg3d_pkg::axis_t  maj_c;
    vlg3d_pkg::axis_t  m1;
    vlg3d_pkg::axis_t  m2;
    vlg3d_pkg::dec_t   dec1_reg;
    vlg3d_pkg::dec_t   dec2_reg;
    vlg3d_pkg::dec_t   dec1_next;
    vlg3d_pkg::dec_t   dec2_next;
    vlg3d_pkg::dec_t   dmaj2;
    logic [vlg3d_pkg::CNT_W-1:0] n_reg;
    logic [2:0]        step_en;

    // major axis: largest extent, ties go to the lower axis
    always_comb begin
        maj_c = vlg3d_pkg::AX_X;
        if (d_reg[1] > d_reg[0]) begin
            maj_c = vlg3d_pkg::AX_Y;
        end
        if (d_reg[2] > d_reg[maj_c]) begin
            maj_c = vlg3d_pkg::AX_Z;
        end
    end

    always_comb begin
        vlg3d_pkg::axis_t a;
        a  = cmd.calc_init ? maj_c : maj_reg;
        m1 = vlg3d_pkg::minor1(a);
        m2 = vlg3d_pkg::minor2(a);
        dmaj2 = vlg3d_pkg::DEC_W'({d_reg[a], 1'b0});
    end

    always_comb begin
        dec1_next = dec1_reg + vlg3d_pkg::DEC_W'({d_reg[m1], 1'b0})
                    - (dec1_reg[vlg3d_pkg::DEC_W-1] ? '0 : dmaj2);
        dec2_next = dec2_reg + vlg3d_pkg::DEC_W'({d_reg[m2], 1'b0})
                    - (dec2_reg[vlg3d_pkg::DEC_W-1] ? '0 : dmaj2);
        for (int i = 0; i < 3; i++) begin
            step_en[i] = (2'(i) == maj_reg)
                       || ((2'(i) == m1) && !dec1_reg[vlg3d_pkg::DEC_W-1])
                       || ((2'(i) == m2) && !dec2_reg[vlg3d_pkg::DEC_W-1]);
            p_next[i]  = p_reg[i] + (step_en[i]
                       ? {{(vlg3d_pkg::COORD_W-2){s_reg[i][1]}}, s_reg[i]}
                       : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            p_reg[0] <= vlg3d_pkg::clamp_coord(start_x);
            p_reg[1] <= vlg3d_pkg::clamp_coord(start_y);
            p_reg[2] <= vlg3d_pkg::clamp_coord(start_z);
            e_reg[0] <= vlg3d_pkg::clamp_coord(end_x);
            e_reg[1] <= vlg3d_pkg::clamp_coord(end_y);
            e_reg[2] <= vlg3d_pkg::clamp_coord(end_z);
            n_reg    <= '0;
        end
        if (cmd.calc_diff) begin
            for (int i = 0; i < 3; i++) begin
                if (e_reg[i] >= p_reg[i]) begin
                    d_reg[i] <= e_reg[i] - p_reg[i];
                    s_reg[i] <= (e_reg[i] != p_reg[i]) ? 2'sd1 : 2'sd0;
                end else begin
                    d_reg[i] <= p_reg[i] - e_reg[i];
                    s_reg[i] <= -2'sd1;
                end
            end
        end
        if (cmd.calc_init) begin
            maj_reg  <= maj_c;
            dec1_reg <= vlg3d_pkg::DEC_W'({d_reg[m1], 1'b0})
                        - vlg3d_pkg::DEC_W'(d_reg[maj_c]);
            dec2_reg <= vlg3d_pkg::DEC_W'({d_reg[m2], 1'b0})
                        - vlg3d_pkg::DEC_W'(d_reg[maj_c]);
        end
        if (cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= p_next[i];
            end
            dec1_reg <= dec1_next;
            dec2_reg <= dec2_next;
            n_reg    <= n_reg + 1'b1;
        end
    end

    assign status.last = (p_reg[maj_reg] == e_reg[maj_reg])
                      || (n_reg == vlg3d_pkg::CNT_W'(vlg3d_pkg::GRID_SIZE - 1));
    assign voxel_x = p_reg[0];
    assign voxel_y = p_reg[1];
    assign voxel_z = p_reg[2];

endmodule
`default_nettype wire

// ----- rtl/voxel_line_3d_generator_core.sv -----
// Top level of the 3D Bresenham voxel line generator.
// After the input transfer the controller passes ST_DIFF and ST_INIT before the
// first voxel is offered. Throughput: one voxel per cycle while m_ready is high.
// s_ready is high only while no line is in progress.
// Synchronous active-low reset returns to idle and withdraws m_valid.
`timescale 1ns / 1ps
`default_nettype none
module voxel_line_3d_generator_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vlg3d_pkg::coord_t   s_start_x,
    input  wire vlg3d_pkg::coord_t   s_start_y,
    input  wire vlg3d_pkg::coord_t   s_start_z,
    input  wire vlg3d_pkg::coord_t   s_end_x,
    input  wire vlg3d_pkg::coord_t   s_end_y,
    input  wire vlg3d_pkg::coord_t   s_end_z,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vlg3d_pkg::coord_t        m_voxel_x,
    output vlg3d_pkg::coord_t        m_voxel_y,
    output vlg3d_pkg::coord_t        m_voxel_z,
    output logic                     m_last_voxel
);

    vlg3d_pkg::cmd_t    cmd;
    vlg3d_pkg::status_t status;

    vlg3d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    vlg3d_dpath u_dpath (
        .aclk    (aclk),
        .cmd     (cmd),
        .start_x (s_start_x),
        .start_y (s_start_y),
        .start_z (s_start_z),
        .end_x   (s_end_x),
        .end_y   (s_end_y),
        .end_z   (s_end_z),
        .voxel_x (m_voxel_x),
        .voxel_y (m_voxel_y),
        .voxel_z (m_voxel_z),
        .status  (status)
    );

    assign m_last_voxel = status.last;

endmodule
`default_nettype wire

// ----- rtl/vlg3d_checker.sv -----
// Port-level checker for the voxel line generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vlg3d_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire vlg3d_pkg::coord_t m_voxel_x,
    input wire logic              m_last_voxel
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a line is in progress");

    a_setup_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("voxel offered right after input transfer");

    a_walk_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_voxel) |=> m_valid)
        else $error("line ended without a last voxel");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_voxel) |=> (s_ready && !m_valid))
        else $error("not idle after last voxel transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_voxel_x)))
        else $error("stalled voxel changed");

endmodule

bind voxel_line_3d_generator_core vlg3d_checker u_vlg3d_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_voxel_x    (m_voxel_x),
    .m_last_voxel (m_last_voxel)
);
`default_nettype wire

// ----- tb/voxel_line_3d_generator_core_test.sv -----
// Self-checking testbench for the 3D Bresenham voxel line generator core.
`timescale 1ns / 1ps
module voxel_line_3d_generator_core_test;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        vlg3d_pkg::coord_t x;
        vlg3d_pkg::coord_t y;
        vlg3d_pkg::coord_t z;
        logic              last;
    } voxel_t;

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    vlg3d_pkg::coord_t s_start_x    = '0;
    vlg3d_pkg::coord_t s_start_y    = '0;
    vlg3d_pkg::coord_t s_start_z    = '0;
    vlg3d_pkg::coord_t s_end_x      = '0;
    vlg3d_pkg::coord_t s_end_y      = '0;
    vlg3d_pkg::coord_t s_end_z      = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    vlg3d_pkg::coord_t m_voxel_x;
    vlg3d_pkg::coord_t m_voxel_y;
    vlg3d_pkg::coord_t m_voxel_z;
    logic              m_last_voxel;

    voxel_t pending_voxels[$];
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    bit     no_idle        = 1'b0;
    bit     hold_request   = 1'b0;

    voxel_line_3d_generator_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_start_z    (s_start_z),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_end_z      (s_end_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_voxel_x    (m_voxel_x),
        .m_voxel_y    (m_voxel_y),
        .m_voxel_z    (m_voxel_z),
        .m_last_voxel (m_last_voxel)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic vlg3d_pkg::coord_t rand_coord();
        return vlg3d_pkg::coord_t'($urandom_range(0, vlg3d_pkg::GRID_SIZE - 1));
    endfunction

    function automatic vlg3d_pkg::coord_t nudge(vlg3d_pkg::coord_t c, int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > vlg3d_pkg::GRID_SIZE - 1) v = vlg3d_pkg::GRID_SIZE - 1;
        return vlg3d_pkg::coord_t'(v);
    endfunction

    // Bresenham walk: queues every voxel from start to end
    task automatic trace_line(input vlg3d_pkg::coord_t sx, input vlg3d_pkg::coord_t sy,
                              input vlg3d_pkg::coord_t sz, input vlg3d_pkg::coord_t ex,
                              input vlg3d_pkg::coord_t ey, input vlg3d_pkg::coord_t ez);
        int               pos[3];
        int               fin[3];
        int               dir[3];
        int               ext[3];
        int               raw[6];
        int               err1;
        int               err2;
        int               n;
        bit               done;
        vlg3d_pkg::axis_t maj;
        vlg3d_pkg::axis_t mn1;
        vlg3d_pkg::axis_t mn2;
        voxel_t           v;
        raw = '{int'(sx), int'(sy), int'(sz), int'(ex), int'(ey), int'(ez)};
        for (int i = 0; i < 6; i++) begin
            if (raw[i] > vlg3d_pkg::GRID_SIZE - 1) raw[i] = vlg3d_pkg::GRID_SIZE - 1;
        end
        for (int i = 0; i < 3; i++) begin
            pos[i] = raw[i];
            fin[i] = raw[i + 3];
            dir[i] = (fin[i] > pos[i]) ? 1 : ((fin[i] < pos[i]) ? -1 : 0);
            ext[i] = (fin[i] > pos[i]) ? fin[i] - pos[i] : pos[i] - fin[i];
        end
        maj = vlg3d_pkg::AX_X;
        if (ext[vlg3d_pkg::AX_Y] > ext[maj]) maj = vlg3d_pkg::AX_Y;
        if (ext[vlg3d_pkg::AX_Z] > ext[maj]) maj = vlg3d_pkg::AX_Z;
        mn1 = (maj == vlg3d_pkg::AX_X) ? vlg3d_pkg::AX_Y : vlg3d_pkg::AX_X;
        mn2 = (maj == vlg3d_pkg::AX_Z) ? vlg3d_pkg::AX_Y : vlg3d_pkg::AX_Z;
        err1 = 2 * ext[mn1] - ext[maj];
        err2 = 2 * ext[mn2] - ext[maj];
        n = 0;
        done = 1'b0;
        while (!done) begin
            v.x = vlg3d_pkg::coord_t'(pos[vlg3d_pkg::AX_X]);
            v.y = vlg3d_pkg::coord_t'(pos[vlg3d_pkg::AX_Y]);
            v.z = vlg3d_pkg::coord_t'(pos[vlg3d_pkg::AX_Z]);
            v.last = (pos[maj] == fin[maj]) || (n >= vlg3d_pkg::GRID_SIZE - 1);
            pending_voxels = {pending_voxels, v};
            n++;
            done = v.last;
            if (!done) begin
                if (err1 >= 0) begin
                    err1 -= 2 * ext[maj];
                    pos[mn1] += dir[mn1];
                end
                if (err2 >= 0) begin
                    err2 -= 2 * ext[maj];
                    pos[mn2] += dir[mn2];
                end
                pos[maj] += dir[maj];
                err1 += 2 * ext[mn1];
                err2 += 2 * ext[mn2];
            end
        end
    endtask

    // Entered just after a transfer edge or a drain, so valid gets one update per step
    task automatic send_line(input vlg3d_pkg::coord_t sx, input vlg3d_pkg::coord_t sy,
                             input vlg3d_pkg::coord_t sz, input vlg3d_pkg::coord_t ex,
                             input vlg3d_pkg::coord_t ey, input vlg3d_pkg::coord_t ez);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_start_x <= sx;
        s_start_y <= sy;
        s_start_z <= sz;
        s_end_x   <= ex;
        s_end_y   <= ey;
        s_end_z   <= ez;
        do @(posedge aclk); while (!(s_valid && s_ready));
        trace_line(sx, sy, sz, ex, ey, ez);
    endtask

    task automatic drain_lines();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_voxels.size() != 0);
    endtask

    task automatic send_random_line();
        vlg3d_pkg::coord_t sx, sy, sz, ex, ey, ez;
        int                kind;
        int                span;
        sx = rand_coord();
        sy = rand_coord();
        sz = rand_coord();
        kind = int'($urandom_range(0, 9));
        if (kind <= 4) begin
            ex = rand_coord();
            ey = rand_coord();
            ez = rand_coord();
        end else if (kind <= 7) begin
            span = int'($urandom_range(1, 6));
            ex = nudge(sx, span);
            ey = nudge(sy, span);
            ez = nudge(sz, span);
        end else if (kind == 8) begin
            // equal extents on two or three axes to hit the tie rules
            span = int'($urandom_range(0, 20));
            ex = nudge(sx, span);
            ey = ($urandom_range(0, 1) != 0) ? nudge(sy, span) : sy;
            ez = ($urandom_range(0, 1) != 0) ? nudge(sz, span) : sz;
            case ($urandom_range(0, 2))
                0: ey = (int'(sy) + span <= vlg3d_pkg::GRID_SIZE - 1)
                        ? vlg3d_pkg::coord_t'(int'(sy) + span) : sy;
                1: ez = (int'(sz) >= span) ? vlg3d_pkg::coord_t'(int'(sz) - span) : sz;
                default: begin
                    ex = (int'(sx) + span <= vlg3d_pkg::GRID_SIZE - 1)
                         ? vlg3d_pkg::coord_t'(int'(sx) + span) : sx;
                    ey = (int'(sy) >= span) ? vlg3d_pkg::coord_t'(int'(sy) - span) : sy;
                end
            endcase
        end else begin
            ex = sx;
            ey = sy;
            ez = sz;
        end
        send_line(sx, sy, sz, ex, ey, ez);
    endtask

    task automatic test_directed();
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
        send_line(6'd0, 6'd0, 6'd0, 6'd63, 6'd63, 6'd63);
        send_line(6'd63, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0);
        send_line(6'd0, 6'd5, 6'd9, 6'd63, 6'd5, 6'd9);
        send_line(6'd63, 6'd0, 6'd63, 6'd0, 6'd63, 6'd0);
        send_line(6'd7, 6'd0, 6'd40, 6'd7, 6'd63, 6'd40);
        send_line(6'd20, 6'd30, 6'd63, 6'd21, 6'd29, 6'd0);
        send_line(6'd0, 6'd0, 6'd0, 6'd10, 6'd10, 6'd3);
        send_line(6'd5, 6'd0, 6'd0, 6'd6, 6'd20, 6'd20);
        send_line(6'd40, 6'd40, 6'd40, 6'd30, 6'd30, 6'd30);
        send_line(6'd10, 6'd10, 6'd10, 6'd11, 6'd9, 6'd10);
        send_line(6'd0, 6'd63, 6'd0, 6'd1, 6'd63, 6'd0);
        send_line(6'd32, 6'd32, 6'd32, 6'd0, 6'd40, 6'd63);
        send_line(6'd1, 6'd2, 6'd3, 6'd60, 6'd17, 6'd45);
        send_line(6'd50, 6'd12, 6'd3, 6'd2, 6'd45, 6'd61);
        send_line(6'd33, 6'd63, 6'd1, 6'd33, 6'd0, 6'd62);
        send_line(6'd42, 6'd21, 6'd63, 6'd42, 6'd21, 6'd62);
        drain_lines();
    endtask

    task automatic test_random();
        repeat (120) send_random_line();
        drain_lines();
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (8) send_random_line();
        drain_lines();
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        repeat (12) send_random_line();
        drain_lines();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_output_stall();
        test_streaming();
        repeat (8) @(posedge aclk);
        if (pending_voxels.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d voxels never arrived", $time, pending_voxels.size());
        end
        if (mismatch_count == 0) begin
            $display("voxel_line_3d_generator_core_test: done, clean");
        end else begin
            $display("voxel_line_3d_generator_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = idle_draw();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
        end
    end

    always @(posedge aclk) begin
        voxel_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (pending_voxels.size() == 0) begin
                mismatch_count++;
                $display("%0t: voxel (%0d,%0d,%0d) with none pending",
                         $time, m_voxel_x, m_voxel_y, m_voxel_z);
            end else begin
                exp_v = pending_voxels.pop_front();
                if (m_voxel_x !== exp_v.x || m_voxel_y !== exp_v.y ||
                    m_voxel_z !== exp_v.z || m_last_voxel !== exp_v.last) begin
                    mismatch_count++;
                    $display("%0t: voxel expected (%0d,%0d,%0d) last %0b %s",
                             $time, exp_v.x, exp_v.y, exp_v.z, exp_v.last,
                             $sformatf("actual (%0d,%0d,%0d) last %0b",
                                       m_voxel_x, m_voxel_y, m_voxel_z, m_last_voxel));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("voxel_line_3d_generator_core_test: done, errors");
            $finish;
        end
    end

endmodule
